@@ src/dqpi_pkg.sv @@
// ----------------------------------------------------------------------------
// dqpi_pkg: shared types and constants for the dq current PI controller
// Register map codes, integrator limits and sequencer state encoding.
// ----------------------------------------------------------------------------
package dqpi_pkg;

  localparam int unsigned IntLimitD = 4194303;
  localparam int unsigned IntLimitQ = 4194303;

  localparam logic [2:0] REG_CUR_LIM = 3'd0;
  localparam logic [2:0] REG_KP_D    = 3'd1;
  localparam logic [2:0] REG_KI_D    = 3'd2;
  localparam logic [2:0] REG_KI_Q    = 3'd3;
  localparam logic [2:0] REG_RES     = 3'd4;
  localparam logic [2:0] REG_FLUX    = 3'd5;
  localparam logic [2:0] REG_VBUS    = 3'd6;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_INTEG = 12'b000000000010,
    ST_M_KPD = 12'b000000000100,
    ST_M_KID = 12'b000000001000,
    ST_M_KIQ = 12'b000000010000,
    ST_M_RES = 12'b000000100000,
    ST_M_FLX = 12'b000001000000,
    ST_M_VB  = 12'b000010000000,
    ST_SQD   = 12'b000100000000,
    ST_M_VD  = 12'b001000000000,
    ST_SQQ   = 12'b010000000000,
    ST_OUT   = 12'b100000000000
  } state_t;

endpackage

@@ src/dq_current_pi_with_voltage_circle.sv @@
// ----------------------------------------------------------------------------
// dq_current_pi_with_voltage_circle: dq current PI with voltage circle limit
// One item at a time: the next input is taken only after the result is
// loaded. A shared 17x25 signed multiplier does every product and every
// square-root trial, including the two square roots for the voltage limits.
// A result still waiting holds the last step.
// Reset (synchronous, rst_n low): registers to defaults, integrators zero.
// ----------------------------------------------------------------------------
module dq_current_pi_with_voltage_circle (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // target_d[15:0], target_q[31:16], measured_d[47:32], measured_q[63:48],
  // elec_speed[79:64]
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // volt_d[15:0], volt_q[31:16]
  output logic [31:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers
  logic [14:0] cur_lim_r, vbus_r;
  logic [15:0] kp_d_r, ki_d_r, ki_q_r, res_r, flux_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_lim_r <= 15'h7fff;
      kp_d_r <= '0; ki_d_r <= '0; ki_q_r <= '0;
      res_r <= '0; flux_r <= '0; vbus_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dqpi_pkg::REG_CUR_LIM: cur_lim_r <= cfg_pwdata[14:0];
        dqpi_pkg::REG_KP_D:    kp_d_r    <= cfg_pwdata[15:0];
        dqpi_pkg::REG_KI_D:    ki_d_r    <= cfg_pwdata[15:0];
        dqpi_pkg::REG_KI_Q:    ki_q_r    <= cfg_pwdata[15:0];
        dqpi_pkg::REG_RES:     res_r     <= cfg_pwdata[15:0];
        dqpi_pkg::REG_FLUX:    flux_r    <= cfg_pwdata[15:0];
        dqpi_pkg::REG_VBUS:    vbus_r    <= cfg_pwdata[14:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      dqpi_pkg::REG_CUR_LIM: cfg_prdata = {17'd0, cur_lim_r};
      dqpi_pkg::REG_KP_D:    cfg_prdata = {16'd0, kp_d_r};
      dqpi_pkg::REG_KI_D:    cfg_prdata = {16'd0, ki_d_r};
      dqpi_pkg::REG_KI_Q:    cfg_prdata = {16'd0, ki_q_r};
      dqpi_pkg::REG_RES:     cfg_prdata = {16'd0, res_r};
      dqpi_pkg::REG_FLUX:    cfg_prdata = {16'd0, flux_r};
      dqpi_pkg::REG_VBUS:    cfg_prdata = {17'd0, vbus_r};
      default:               cfg_prdata = '0;
    endcase
  end

  // bus voltage split as 3*k + r; k by reciprocal multiply, tracked each cycle
  logic [14:0] vb3_r;
  logic [29:0] vb3_prod;
  logic [14:0] vb_rem;
  logic [15:0] vb_sum;
  assign vb3_prod = 30'(vbus_r) * 30'd21846;
  assign vb_rem   = vbus_r - {vb3_r[13:0], 1'b0} - vb3_r;
  assign vb_sum   = 16'(vbus_r) + 16'(vb_rem);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb3_r <= '0;
    end else begin
      vb3_r <= {1'b0, vb3_prod[29:16]};
    end
  end

  // datapath registers
  dqpi_pkg::state_t state_r;
  logic signed [16:0] ed_r, eq_r, tq_r, spd_r;
  logic signed [23:0] integ_d_r, integ_q_r;
  logic signed [47:0] acc_r;     // d sum, later q sum
  logic signed [15:0] vd_r, vq_r;
  logic [29:0]        c_r;       // vbus^2/3, radicand of the d root
  logic [14:0]        limd_r;
  logic [29:0]        rem_r;
  logic [15:0]        root_r;
  logic [3:0]         cnt_r;
  logic [31:0]        out_r;
  logic               out_vld_r;
  logic               out_free;

  assign in_tready  = (state_r == dqpi_pkg::ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;
  assign out_free   = ~out_vld_r | out_tready;

  // capture and error formation
  logic signed [15:0] in_td, in_tq, in_md, in_mq;
  logic signed [16:0] lim_s, tq_c;
  assign in_td = in_tdata[15:0];
  assign in_tq = in_tdata[31:16];
  assign in_md = in_tdata[47:32];
  assign in_mq = in_tdata[63:48];
  assign lim_s = signed'({2'b00, cur_lim_r});
  always_comb begin
    tq_c = 17'(in_tq);
    if (tq_c > lim_s) tq_c = lim_s;
    else if (tq_c < -lim_s) tq_c = -lim_s;
  end

  // square root step: one result bit per cycle, trial squared on the multiplier
  logic [15:0] trial;
  logic [15:0] bitv;
  assign bitv  = 16'(16'h8000 >> cnt_r);
  assign trial = root_r | bitv;

  // shared multiplier: 17-bit signed by 25-bit signed operand
  logic signed [16:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [41:0] mul_p;
  always_comb begin
    mul_a = '0; mul_b = '0;
    case (state_r)
      dqpi_pkg::ST_M_KPD: begin mul_a = ed_r;  mul_b = signed'({9'd0, kp_d_r}); end
      dqpi_pkg::ST_M_KID: begin mul_a = signed'({1'b0, ki_d_r}); mul_b = 25'(integ_d_r); end
      dqpi_pkg::ST_M_KIQ: begin mul_a = signed'({1'b0, ki_q_r}); mul_b = 25'(integ_q_r); end
      dqpi_pkg::ST_M_RES: begin mul_a = tq_r;  mul_b = signed'({9'd0, res_r}); end
      dqpi_pkg::ST_M_FLX: begin mul_a = spd_r; mul_b = signed'({9'd0, flux_r}); end
      dqpi_pkg::ST_M_VB:  begin mul_a = signed'({2'b0, vb3_r}); mul_b = signed'({9'd0, vb_sum}); end
      dqpi_pkg::ST_M_VD:  begin mul_a = 17'(vd_r); mul_b = 25'(vd_r); end
      dqpi_pkg::ST_SQD,
      dqpi_pkg::ST_SQQ:   begin mul_a = signed'({1'b0, trial}); mul_b = signed'({9'd0, trial}); end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  logic        take;
  assign take = mul_p[32:0] <= {3'd0, rem_r};

  // vbus^2/3 = k*(vbus + r), plus one when r is two
  logic [29:0] c_nxt;
  assign c_nxt = mul_p[29:0] + {29'd0, vb_rem == 15'd2};

  // integrator update
  function automatic logic signed [23:0] integ_upd(input logic signed [23:0] i,
                                                   input logic signed [16:0] e,
                                                   input int unsigned lim);
    logic signed [24:0] s, l;
    begin
      s = 25'(i) + 25'(e);
      l = signed'(25'(lim));
      if (s > l) s = l;
      else if (s < -l) s = -l;
      integ_upd = s[23:0];
    end
  endfunction

  // floor shift and saturate to 16 bits
  function automatic logic signed [15:0] sat_sh(input logic signed [47:0] v,
                                                input logic sh16);
    logic signed [47:0] f;
    begin
      f = sh16 ? (v >>> 16) : (v >>> 8);
      if (f > 48'sd32767) sat_sh = 16'sh7fff;
      else if (f < -48'sd32768) sat_sh = 16'sh8000;
      else sat_sh = f[15:0];
    end
  endfunction

  logic signed [15:0] vq_cl, vd_cl;
  logic [30:0] vd2;
  logic signed [16:0] lq;
  always_comb begin
    vd2 = 31'(mul_p[30:0]);
    lq  = signed'({1'b0, root_r});
    vq_cl = vq_r;
    if (17'(vq_r) > lq) vq_cl = lq[15:0];
    else if (17'(vq_r) < -lq) vq_cl = 16'(-lq);
    vd_cl = vd_r;
    if (17'(vd_r) > signed'({2'b0, limd_r})) vd_cl = signed'({1'b0, limd_r});
    else if (17'(vd_r) < -signed'({2'b0, limd_r})) vd_cl = -signed'({1'b0, limd_r});
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dqpi_pkg::ST_IDLE;
      out_vld_r <= 1'b0;
      integ_d_r <= '0; integ_q_r <= '0;
      cnt_r <= '0;
    end else begin
      // load a result when the output is free, drop it once taken
      if (state_r == dqpi_pkg::ST_OUT && out_free) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
      case (state_r)
        dqpi_pkg::ST_IDLE: if (in_tvalid && in_tready) begin
          ed_r  <= 17'(in_td) - 17'(in_md);
          eq_r  <= tq_c - 17'(in_mq);
          tq_r  <= tq_c;
          spd_r <= 17'(signed'(in_tdata[79:64]));
          state_r <= dqpi_pkg::ST_INTEG;
        end
        dqpi_pkg::ST_INTEG: begin
          integ_d_r <= integ_upd(integ_d_r, ed_r, dqpi_pkg::IntLimitD);
          integ_q_r <= integ_upd(integ_q_r, eq_r, dqpi_pkg::IntLimitQ);
          state_r <= dqpi_pkg::ST_M_KPD;
        end
        dqpi_pkg::ST_M_KPD: begin
          acc_r <= 48'(mul_p);
          state_r <= dqpi_pkg::ST_M_KID;
        end
        dqpi_pkg::ST_M_KID: begin
          vd_r <= sat_sh(acc_r + 48'(mul_p), 1'b0);
          state_r <= dqpi_pkg::ST_M_KIQ;
        end
        dqpi_pkg::ST_M_KIQ: begin
          acc_r <= 48'(mul_p) <<< 8;
          state_r <= dqpi_pkg::ST_M_RES;
        end
        dqpi_pkg::ST_M_RES: begin
          acc_r <= acc_r + 48'(mul_p);
          state_r <= dqpi_pkg::ST_M_FLX;
        end
        dqpi_pkg::ST_M_FLX: begin
          vq_r <= sat_sh(acc_r + 48'(mul_p), 1'b1);
          state_r <= dqpi_pkg::ST_M_VB;
        end
        dqpi_pkg::ST_M_VB: begin
          c_r <= c_nxt;
          rem_r <= c_nxt;
          root_r <= '0; cnt_r <= '0;
          state_r <= dqpi_pkg::ST_SQD;
        end
        dqpi_pkg::ST_SQD: begin
          if (take) root_r <= trial;
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) state_r <= dqpi_pkg::ST_M_VD;
        end
        dqpi_pkg::ST_M_VD: begin
          limd_r <= root_r[14:0];
          rem_r  <= (31'(c_r) > vd2) ? 30'(31'(c_r) - vd2) : '0;
          root_r <= '0; cnt_r <= '0;
          state_r <= dqpi_pkg::ST_SQQ;
        end
        dqpi_pkg::ST_SQQ: begin
          if (take) root_r <= trial;
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) state_r <= dqpi_pkg::ST_OUT;
        end
        dqpi_pkg::ST_OUT: if (out_free) begin
          out_r <= {vq_cl, vd_cl};
          state_r <= dqpi_pkg::ST_IDLE;
        end
        default: state_r <= dqpi_pkg::ST_IDLE;
      endcase
    end
  end

endmodule
